// ----- design/b64e_pkg.sv -----
// Shared types, constants and the Base64 alphabet lookup for the stream encoder.
package b64e_pkg;

  localparam int unsigned CharW    = 7;
  localparam int unsigned MaxChars = 5;
  localparam int unsigned CntW     = 3;

  localparam logic [CharW-1:0] PadChar   = 7'h3D;
  localparam logic [CharW-1:0] DigitZero = 7'h30;

  // Byte position within the current three-byte group.
  typedef enum logic [1:0] {
    PHASE_FIRST  = 2'd0,
    PHASE_SECOND = 2'd1,
    PHASE_THIRD  = 2'd2
  } phase_e;

  // Characters produced by one input transaction, slot 0 goes out first.
  typedef struct packed {
    logic [MaxChars-1:0][CharW-1:0] chars;
    logic [CntW-1:0]                count;
    logic                           eot;
  } char_list_t;

  // Maps a sextet onto the standard alphabet A-Z a-z 0-9 + /.
  function automatic logic [CharW-1:0] sextet_char(input logic [5:0] v);
    logic [CharW-1:0] ch;
    if (v < 6'd26) begin
      ch = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      ch = 7'h61 + {1'b0, v - 6'd26};
    end else if (v < 6'd62) begin
      ch = 7'h30 + {1'b0, v - 6'd52};
    end else if (v == 6'd62) begin
      ch = 7'h2B;
    end else begin
      ch = 7'h2F;
    end
    return ch;
  endfunction

endpackage

// ----- design/base64_stream_encoder.sv -----
// Base64 stream encoder: one raw byte in, prefix, alphabet and pad characters out.
// Output: the first character of a byte is registered and appears in the cycle after its transaction.
// Throughput: one character per cycle while the output port is ready; a byte yields
// one or two characters, up to five at buffer start or end.
// Reset: asynchronous active low; item size returns to 1, group state clears,
// and the next byte starts a new buffer with its prefix character.
module base64_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,    // item_size
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic       m_axis_tlast    // end_of_text
);

  b64e_pkg::char_list_t         list;
  logic                         accept;
  logic                         load_ready;
  logic [b64e_pkg::CharW-1:0]   out_char;

  assign s_axis_tready = load_ready;
  assign accept        = s_axis_tvalid && load_ready;
  assign m_axis_tdata  = {1'b0, out_char};

  b64e_group_encode u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .list_o      (list)
  );

  b64e_out_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .list_i       (list),
    .load_ready_o (load_ready),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .char_o       (out_char),
    .last_o       (m_axis_tlast)
  );

endmodule

// ----- design/b64e_group_encode.sv -----
// Group state, item size register and per-byte character generation.
module b64e_group_encode (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_wdata_i,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output b64e_pkg::char_list_t list_o
);

  logic [3:0]       item_size_q;
  b64e_pkg::phase_e phase_q, phase_d;
  logic [7:0]       held_q, held_d;
  logic             start_q;

  logic [3:0][b64e_pkg::CharW-1:0] base;
  logic [b64e_pkg::CntW-1:0]       base_n;
  logic [b64e_pkg::CharW-1:0]      prefix;

  assign prefix = b64e_pkg::DigitZero + {3'b000, item_size_q};

  always_comb begin
    base    = '0;
    base_n  = '0;
    phase_d = phase_q;
    held_d  = held_q;
    case (phase_q)
      b64e_pkg::PHASE_SECOND: begin
        base[0] = b64e_pkg::sextet_char({held_q[1:0], data_byte_i[7:4]});
        if (last_byte_i) begin
          base[1] = b64e_pkg::sextet_char({data_byte_i[3:0], 2'b00});
          base[2] = b64e_pkg::PadChar;
          base_n  = 3'd3;
        end else begin
          base_n  = 3'd1;
          held_d  = data_byte_i;
          phase_d = b64e_pkg::PHASE_THIRD;
        end
      end
      b64e_pkg::PHASE_THIRD: begin
        base[0] = b64e_pkg::sextet_char({held_q[3:0], data_byte_i[7:6]});
        base[1] = b64e_pkg::sextet_char(data_byte_i[5:0]);
        base_n  = 3'd2;
        phase_d = b64e_pkg::PHASE_FIRST;
      end
      default: begin
        base[0] = b64e_pkg::sextet_char(data_byte_i[7:2]);
        if (last_byte_i) begin
          base[1] = b64e_pkg::sextet_char({data_byte_i[1:0], 4'b0000});
          base[2] = b64e_pkg::PadChar;
          base[3] = b64e_pkg::PadChar;
          base_n  = 3'd4;
        end else begin
          base_n  = 3'd1;
          held_d  = data_byte_i;
          phase_d = b64e_pkg::PHASE_SECOND;
        end
      end
    endcase
    if (last_byte_i) begin
      phase_d = b64e_pkg::PHASE_FIRST;
      held_d  = '0;
    end
  end

  // The prefix character, when due, takes slot 0 and pushes the group characters up.
  always_comb begin
    list_o.chars = start_q ? {base, prefix} : {{b64e_pkg::CharW{1'b0}}, base};
    list_o.count = base_n + {2'b00, start_q};
    list_o.eot   = last_byte_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_size_q <= 4'd1;
      phase_q     <= b64e_pkg::PHASE_FIRST;
      held_q      <= '0;
      start_q     <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        item_size_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        start_q <= last_byte_i;
      end
    end
  end

endmodule

// ----- design/b64e_out_queue.sv -----
// Result register holding up to five characters, drained one per transaction.
module b64e_out_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  b64e_pkg::char_list_t        list_i,
  output logic                        load_ready_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [b64e_pkg::CharW-1:0]  char_o,
  output logic                        last_o
);

  logic [b64e_pkg::MaxChars-1:0][b64e_pkg::CharW-1:0] chars_q;
  logic [b64e_pkg::CntW-1:0]                          cnt_q;
  logic                                               eot_q;
  logic                                               pop;

  assign valid_o      = (cnt_q != '0);
  assign pop          = valid_o && ready_i;
  assign char_o       = chars_q[0];
  assign last_o       = eot_q && (cnt_q == 3'd1);
  // A new list may load in the same cycle that the final character leaves.
  assign load_ready_o = (cnt_q == '0) || ((cnt_q == 3'd1) && ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= list_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chars_q <= list_i.chars;
      eot_q   <= list_i.eot;
    end else if (pop) begin
      chars_q <= {{b64e_pkg::CharW{1'b0}}, chars_q[b64e_pkg::MaxChars-1:1]};
    end
  end

endmodule

// ----- sim/b64e_checker.sv -----
`timescale 1ns / 1ps
// Checker for the Base64 stream encoder: predicts characters per byte and compares them.
module b64e_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,
  input  logic        m_tlast_i,
  output int unsigned chars_pending_o,
  output int unsigned error_count_o
);

  localparam logic [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [b64e_pkg::CharW-1:0] ch;
    logic                       eot;
  } enc_char_t;

  enc_char_t          expected_chars[$];
  logic [3:0]         item_size;
  b64e_pkg::phase_e   group_pos;
  logic [7:0]         prev_byte;
  logic               need_prefix;
  int unsigned        errors;
  int unsigned        chars_seen;

  function automatic logic [b64e_pkg::CharW-1:0] alphabet_char(input logic [5:0] v);
    int pos;
    pos = 8 * (63 - int'(v));
    return Alphabet[pos +: 7];
  endfunction

  task automatic push_char(input logic [b64e_pkg::CharW-1:0] ch, input logic eot);
    enc_char_t c;
    c.ch  = ch;
    c.eot = eot;
    expected_chars.push_back(c);
  endtask

  // Appends the characters that one accepted byte produces.
  task automatic encode_byte(input logic [7:0] b, input logic last);
    if (need_prefix) begin
      push_char({3'b000, item_size} + b64e_pkg::DigitZero, 1'b0);
      need_prefix = 1'b0;
    end
    case (group_pos)
      b64e_pkg::PHASE_SECOND: begin
        push_char(alphabet_char({prev_byte[1:0], b[7:4]}), 1'b0);
        if (last) begin
          push_char(alphabet_char({b[3:0], 2'b00}), 1'b0);
          push_char(b64e_pkg::PadChar, 1'b1);
        end else begin
          prev_byte = b;
          group_pos = b64e_pkg::PHASE_THIRD;
        end
      end
      b64e_pkg::PHASE_THIRD: begin
        push_char(alphabet_char({prev_byte[3:0], b[7:6]}), 1'b0);
        push_char(alphabet_char(b[5:0]), last);
        group_pos = b64e_pkg::PHASE_FIRST;
      end
      default: begin
        push_char(alphabet_char(b[7:2]), 1'b0);
        if (last) begin
          push_char(alphabet_char({b[1:0], 4'b0000}), 1'b0);
          push_char(b64e_pkg::PadChar, 1'b0);
          push_char(b64e_pkg::PadChar, 1'b1);
        end else begin
          prev_byte = b;
          group_pos = b64e_pkg::PHASE_SECOND;
        end
      end
    endcase
    if (last) begin
      group_pos   = b64e_pkg::PHASE_FIRST;
      prev_byte   = 8'h00;
      need_prefix = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: character %0d: %s", $realtime, chars_seen, msg);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    enc_char_t want;
    if (!rst_ni) begin
      expected_chars.delete();
      item_size       = 4'd1;
      group_pos       = b64e_pkg::PHASE_FIRST;
      prev_byte       = 8'h00;
      need_prefix     = 1'b1;
      errors          = 0;
      chars_seen      = 0;
      chars_pending_o <= 0;
      error_count_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        item_size = cfg_wdata_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        encode_byte(s_tdata_i, s_tlast_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                    m_tdata_i, m_tlast_i));
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata_i !== {1'b0, want.ch}) begin
            report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                      m_tdata_i, {1'b0, want.ch}));
          end
          if (m_tlast_i !== want.eot) begin
            report_mismatch($sformatf("end_of_text %0b, expected %0b",
                                      m_tlast_i, want.eot));
          end
        end
        chars_seen++;
      end
      chars_pending_o <= expected_chars.size();
      error_count_o   <= errors;
    end
  end

endmodule

// ----- sim/tb_base64_stream_encoder.sv -----
`timescale 1ns / 1ps
// Testbench top for the Base64 stream encoder: stimulus, receiver stalls and verdict.
module tb_base64_stream_encoder;

  localparam int unsigned PhaseBytes = 45;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned MaxGap     = 12;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [3:0]  cfg_wdata_i   = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  int unsigned chars_pending;
  int unsigned error_count;

  int          sender_idle_pct   = 0;
  int          receiver_stall_pct = 0;
  int          bytes_left_in_buf = 0;

  base64_stream_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  b64e_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tlast_i       (s_axis_tlast),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tlast_i       (m_axis_tlast),
    .chars_pending_o (chars_pending),
    .error_count_o   (error_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Offers one byte, possibly after an idle gap, and returns at its accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(0, 99) < sender_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering bytes and waits until every predicted character has left.
  task automatic drain_encoder();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (chars_pending != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_item_size(input logic [3:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random buffers, mostly short; a buffer may stay open across a phase boundary.
  task automatic send_random_bytes(input int count);
    logic [7:0] b;
    int         pick;
    for (int i = 0; i < count; i++) begin
      if (bytes_left_in_buf == 0) begin
        bytes_left_in_buf = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6)
                                                        : $urandom_range(7, 20);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        b = 8'h00;
      end else if (pick == 1) begin
        b = 8'hFF;
      end else begin
        b = 8'($urandom);
      end
      send_byte(b, bytes_left_in_buf == 1);
      bytes_left_in_buf--;
    end
  endtask

  initial begin
    logic [3:0] phase_sizes[NumPhases];
    phase_sizes = '{4'd0, 4'd9, 4'd15, 4'd5, 4'd1, 4'($urandom_range(2, 8))};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed buffers at the reset item size: one-byte and two-byte tails,
    // a full group, and a group that maps onto '+' and '/'.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    drain_encoder();

    for (int p = 0; p < NumPhases; p++) begin
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
        default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
      endcase
      write_item_size(phase_sizes[p]);
      send_random_bytes(PhaseBytes);
      drain_encoder();
    end

    @(negedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
